FILE: hdl/ifil_pkg.sv
// ----------------------------------------------------------------------------
// ifil_pkg
// Shared types and constants of the IPv4 address filter table.
// ----------------------------------------------------------------------------
package ifil_pkg;

	localparam int unsigned ENTRIES_DEF = 64;
	localparam int unsigned ADDR_W      = 32;
	localparam int unsigned ACT_W       = 2;

	// Action codes; the unused code is handled as a lookup
	localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ADD    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

	// Search token walking the row of cells
	typedef struct packed {
		logic live;  // token carries an item
		logic hit;   // a valid cell upstream held the key
		logic free;  // a free cell upstream was already claimed
	} tok_t;

	// Commit command broadcast to every cell at the end of a walk
	typedef struct packed {
		logic add;   // write key into the claimed free cell
		logic del;   // clear the cell that matched
	} cmd_t;

endpackage

FILE: hdl/ipv4_address_filter_table.sv
// ----------------------------------------------------------------------------
// ipv4_address_filter_table
// Exact-match set of IPv4 addresses for a packet filter: lookup, add, delete.
// ----------------------------------------------------------------------------
// Each item is walked through the table before the next item can be taken:
// the search token walks the row of ENTRIES slot cells one cell per cycle,
// after a launch register, and the table update is committed as the walk ends.
// The result is registered as the walk ends, into the output register or, while
// that holds an untaken result, into a skid register, so a new item is accepted
// while an earlier result is still waiting to be taken. found reports whether
// the address was present before the item; table_full flags an add of a new
// address dropped because every slot was in use. Adds take the lowest free
// slot, deletes clear the matching slot, and action code 3 acts as a lookup.
// All valid marks are cleared by reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ipv4_address_filter_table import ifil_pkg::*; #(
	parameter int unsigned ENTRIES = ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ACT_W-1:0]  action,
	input  logic [ADDR_W-1:0] address,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              found,
	output logic              table_full
);

	// Token links between neighbouring cells: link 0 is the launch,
	// link ENTRIES is the token leaving the last cell
	tok_t              tok_link [ENTRIES+1];
	logic [ADDR_W-1:0] key;
	cmd_t              cmd;

	// Intake, commit decision and result hold
	ifil_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.address    (address),
		.tok_start  (tok_link[0]),
		.tok_end    (tok_link[ENTRIES]),
		.key        (key),
		.cmd        (cmd),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.found      (found),
		.table_full (table_full)
	);

	// Row of slot cells; the key and commit command are broadcast, the
	// token hops from each cell to the next every cycle
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		ifil_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_i  (tok_link[i]),
			.tok_o  (tok_link[i+1]),
			.key    (key),
			.cmd    (cmd)
		);
	end

endmodule

FILE: hdl/ifil_cell.sv
// ----------------------------------------------------------------------------
// ifil_cell
// One table slot: valid mark, stored address and one stage of the search walk.
// ----------------------------------------------------------------------------
module ifil_cell import ifil_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  tok_t              tok_i,
	output tok_t              tok_o,
	input  logic [ADDR_W-1:0] key,
	input  cmd_t              cmd
);

	logic              valid_q;
	logic [ADDR_W-1:0] addr_q;
	logic              sel_hit_q;
	logic              sel_free_q;
	tok_t              tok_q;
	logic              match;

	assign match = valid_q && (addr_q == key);
	assign tok_o = tok_q;

	// Advance the token one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.live <= tok_i.live;
			tok_q.hit  <= tok_i.live && (tok_i.hit || match);
			tok_q.free <= tok_i.live && (tok_i.free || !valid_q);
		end
	end

	// Remember whether this cell is the match or the lowest free slot
	always_ff @(posedge clk) begin
		if (tok_i.live) begin
			sel_hit_q  <= match;
			sel_free_q <= !valid_q && !tok_i.free;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.add && sel_free_q) begin
			valid_q <= 1'b1;
		end else if (cmd.del && sel_hit_q) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add && sel_free_q) begin
			addr_q <= key;
		end
	end

endmodule

FILE: hdl/ifil_ctrl.sv
// ----------------------------------------------------------------------------
// ifil_ctrl
// Item intake, walk launch, commit decision and result register with skid.
// ----------------------------------------------------------------------------
module ifil_ctrl import ifil_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ACT_W-1:0]  action,
	input  logic [ADDR_W-1:0] address,
	output tok_t              tok_start,
	input  tok_t              tok_end,
	output logic [ADDR_W-1:0] key,
	output cmd_t              cmd,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              found,
	output logic              table_full
);

	logic              busy_q;
	logic              start_q;
	logic [ACT_W-1:0]  act_q;
	logic [ADDR_W-1:0] key_q;
	logic              out_valid_q;
	logic              out_found_q;
	logic              out_full_q;
	logic              skid_valid_q;
	logic              skid_found_q;
	logic              skid_full_q;

	logic accept;
	logic walk_done;
	logic out_free;
	logic out_take;
	logic is_add;
	logic res_full;

	assign in_ready  = !busy_q && !skid_valid_q;
	assign accept    = in_valid && in_ready;
	assign walk_done = tok_end.live;
	assign out_free  = !out_valid_q || out_ready;
	assign out_take  = out_valid_q && out_ready;
	assign is_add    = (act_q == ACT_ADD);
	assign res_full  = is_add && !tok_end.hit && !tok_end.free;

	assign tok_start = '{live: start_q, hit: 1'b0, free: 1'b0};
	assign key       = key_q;

	assign cmd.add = walk_done && is_add && !tok_end.hit && tok_end.free;
	assign cmd.del = walk_done && (act_q == ACT_DELETE) && tok_end.hit;

	assign out_valid  = out_valid_q;
	assign found      = out_found_q;
	assign table_full = out_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			start_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			start_q <= accept;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (walk_done) begin
				busy_q <= 1'b0;
			end
			priority if (walk_done && out_free) begin
				out_valid_q <= 1'b1;
			end else if (walk_done) begin
				skid_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q  <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			key_q <= address;
		end
		priority if (walk_done && out_free) begin
			out_found_q <= tok_end.hit;
			out_full_q  <= res_full;
		end else if (walk_done) begin
			skid_found_q <= tok_end.hit;
			skid_full_q  <= res_full;
		end else if (out_take && skid_valid_q) begin
			out_found_q <= skid_found_q;
			out_full_q  <= skid_full_q;
		end
	end

endmodule

FILE: bench/ipv4_address_filter_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv4_address_filter_table_tb
// Self-checking bench for the IPv4 exact-match address table.
// ----------------------------------------------------------------------------
// Items (action, address) are pushed through the valid/ready input channel and
// every item accepted is run through a behavioural copy of the table. That copy
// yields the found / table_full verdict, which is queued. Each result taken at
// the output is checked against the oldest queued verdict. The run covers
// directed corner cases, filling the table to overflow, random traffic from an
// address pool under several idle and stall mixes, and a long output stall.
// ----------------------------------------------------------------------------
module ipv4_address_filter_table_tb import ifil_pkg::*; ();

	localparam int unsigned SLOTS      = ENTRIES_DEF;
	localparam int unsigned POOL_SIZE  = SLOTS + 32;
	localparam int unsigned QUIET_MAX  = 5000;
	localparam int unsigned MAX_PRINTS = 40;

	// Action code 3 has no meaning of its own; the block treats it as a lookup
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic found;
		logic full;
	} verdict_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [ACT_W-1:0]  action = ACT_LOOKUP;
	logic [ADDR_W-1:0] address = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              found;
	logic              table_full;

	// Behavioural copy of the table
	bit                model_valid [SLOTS];
	bit [ADDR_W-1:0]   model_addr  [SLOTS];

	verdict_t          expected_verdicts [$];
	bit [ADDR_W-1:0]   addr_pool [POOL_SIZE];

	int                tx_idle_pct = 0;
	int                rx_stall_pct = 0;
	logic              rx_hold = 1'b0;
	int unsigned       err_count = 0;
	int unsigned       quiet_cycles = 0;

	ipv4_address_filter_table #(
		.ENTRIES(SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.address(address),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.table_full(table_full)
	);

	always #4 clk = ~clk;

	// Work out the verdict of one item and apply it to the table copy.
	// Matching and the lowest free slot are judged on the table before the item.
	function automatic verdict_t table_apply(logic [ACT_W-1:0] act, logic [ADDR_W-1:0] key);
		int hit;
		int spare;
		verdict_t v;
		hit = -1;
		spare = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (hit < 0 && model_valid[i] && model_addr[i] == key)
				hit = i;
			if (spare < 0 && !model_valid[i])
				spare = i;
		end
		v.found = (hit >= 0);
		v.full = 1'b0;
		if (act == ACT_ADD && hit < 0) begin
			if (spare >= 0) begin
				model_valid[spare] = 1'b1;
				model_addr[spare] = key;
			end else begin
				v.full = 1'b1;
			end
		end else if (act == ACT_DELETE && hit >= 0) begin
			model_valid[hit] = 1'b0;
		end
		return v;
	endfunction

	task automatic report_mismatch(string what, logic got, logic want);
		if (err_count < MAX_PRINTS)
			$display("[%0t] mismatch on %s: got %b, expected %b", $realtime, what, got, want);
		err_count++;
	endtask

	// Predict at acceptance: the verdict depends on the table as it stands then
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			expected_verdicts.push_back(table_apply(action, address));
	end

	// Check each result taken against the oldest verdict waiting
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_verdicts.size() == 0) begin
				report_mismatch("result with no item outstanding", out_valid, 1'b0);
			end else begin
				want = expected_verdicts.pop_front();
				if (found !== want.found)
					report_mismatch("found", found, want.found);
				if (table_full !== want.full)
					report_mismatch("table_full", table_full, want.full);
			end
		end
	end

	// Receiver: stall at random, or hold off entirely while rx_hold is set
	always @(posedge clk) begin
		out_ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
	end

	// Watchdog: end the run if no item moves on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_MAX) begin
				$display("ipv4_address_filter_table_tb failed");
				$finish;
			end
		end
	end

	// Offer one item and hold it until the block takes it. An idle gap, when
	// drawn, is long enough to land on any point of the block's slot walk.
	task automatic send_item(logic [ACT_W-1:0] act, logic [ADDR_W-1:0] key);
		int gap;
		gap = 0;
		if ($urandom_range(99) < tx_idle_pct)
			gap = $urandom_range(1, 2 * (SLOTS + 2));
		repeat (gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		address <= key;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Distinct addresses; the two extremes always take the first places
	task automatic build_pool();
		bit [ADDR_W-1:0] cand;
		bit dup;
		addr_pool[0] = '0;
		addr_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++) begin
			do begin
				cand = $urandom();
				dup = 1'b0;
				for (int j = 0; j < i; j++)
					if (addr_pool[j] == cand)
						dup = 1'b1;
			end while (dup);
			addr_pool[i] = cand;
		end
	endtask

	// Mostly pool addresses so that hits are common, now and then a stray one
	function automatic logic [ADDR_W-1:0] pick_address(int pool_n);
		if ($urandom_range(99) < 85)
			return addr_pool[$urandom_range(pool_n - 1)];
		return $urandom();
	endfunction

	function automatic logic [ACT_W-1:0] pick_action(int add_pct);
		int roll;
		roll = $urandom_range(99);
		if (roll < add_pct)
			return ACT_ADD;
		if (roll < add_pct + 30)
			return ACT_DELETE;
		if (roll < add_pct + 35)
			return ACT_UNUSED;
		return ACT_LOOKUP;
	endfunction

	// Lookup, add and delete on both extreme addresses, duplicates, absent deletes and
	// the unused code on both a present and an absent address
	task automatic test_directed_ops();
		send_item(ACT_LOOKUP, 32'h0000_0000);
		send_item(ACT_ADD,    32'h0000_0000);
		send_item(ACT_ADD,    32'h0000_0000);
		send_item(ACT_LOOKUP, 32'h0000_0000);
		send_item(ACT_ADD,    32'hFFFF_FFFF);
		send_item(ACT_LOOKUP, 32'hFFFF_FFFF);
		send_item(ACT_UNUSED, 32'hFFFF_FFFF);
		send_item(ACT_UNUSED, 32'h1234_5678);
		send_item(ACT_LOOKUP, 32'h1234_5678);
		send_item(ACT_DELETE, 32'h0000_0000);
		send_item(ACT_DELETE, 32'h0000_0000);
		send_item(ACT_LOOKUP, 32'h0000_0000);
		send_item(ACT_ADD,    32'h8000_0000);
		send_item(ACT_ADD,    32'h0000_0001);
		send_item(ACT_ADD,    32'h7FFF_FFFF);
		send_item(ACT_LOOKUP, 32'h8000_0001);
		send_item(ACT_LOOKUP, 32'h7FFF_FFFF);
		send_item(ACT_DELETE, 32'hFFFF_FFFF);
		send_item(ACT_LOOKUP, 32'hFFFF_FFFF);
		send_item(ACT_DELETE, 32'h8000_0000);
		send_item(ACT_DELETE, 32'h0000_0001);
		send_item(ACT_DELETE, 32'h7FFF_FFFF);
	endtask

	// Fill every slot, overflow it, free a slot in the middle, refill it,
	// overflow again, then drain the table
	task automatic test_table_overflow();
		for (int i = 0; i < SLOTS + 16; i++)
			send_item(ACT_ADD, addr_pool[i]);
		send_item(ACT_ADD, addr_pool[0]);
		send_item(ACT_LOOKUP, addr_pool[SLOTS + 20]);
		send_item(ACT_DELETE, addr_pool[5]);
		send_item(ACT_ADD, addr_pool[SLOTS + 20]);
		send_item(ACT_ADD, addr_pool[SLOTS + 21]);
		send_item(ACT_LOOKUP, addr_pool[SLOTS + 20]);
		for (int i = 0; i < POOL_SIZE; i++)
			send_item(ACT_DELETE, addr_pool[i]);
	endtask

	task automatic test_random_traffic(int count, int pool_n, int add_pct, int tx_pct, int rx_pct);
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		repeat (count)
			send_item(pick_action(add_pct), pick_address(pool_n));
	endtask

	// Hold the output off for a long stretch while items keep coming, so that
	// the result registers fill and the input stalls
	task automatic test_output_backpressure();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		fork
			begin
				rx_hold <= 1'b1;
				repeat (8 * (SLOTS + 2)) @(posedge clk);
				rx_hold <= 1'b0;
			end
			repeat (12)
				send_item(pick_action(40), pick_address(24));
		join
	endtask

	initial begin
		build_pool();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_ops();
		test_table_overflow();
		test_random_traffic(90, 24, 35, 0, 0);
		test_random_traffic(90, 24, 35, 52, 0);
		test_random_traffic(90, 24, 35, 0, 52);
		test_random_traffic(90, 24, 35, 8, 8);
		test_random_traffic(90, POOL_SIZE, 60, 8, 8);
		test_output_backpressure();

		in_valid <= 1'b0;
		rx_stall_pct = 0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (2 * (SLOTS + 2)) @(posedge clk);

		if (err_count == 0)
			$display("ipv4_address_filter_table_tb passed");
		else
			$display("ipv4_address_filter_table_tb failed");
		$finish;
	end

endmodule

FILE: ipv4_address_filter_table.f
hdl/ifil_pkg.sv
hdl/ifil_cell.sv
hdl/ifil_ctrl.sv
hdl/ipv4_address_filter_table.sv
bench/ipv4_address_filter_table_tb.sv
